FILE: src/cflru_pkg.sv
// Shared types and constants for the clean-first LRU page frame block.
// Used by cflru_cell, cflru_sel and clean_first_lru_page_frames_top.
package cflru_pkg;

	localparam int MAX_FRAMES = 64;
	localparam int ADDR_W     = 64;
	localparam int PAGE_SHIFT = 12;
	localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
	localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
	localparam int CFG_W      = 7;
	localparam int CMP_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int TOT_W      = 32;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLEAN_WINDOW  = 1'd1;

	localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 7'd64;
	localparam logic [CFG_W-1:0] CLEAN_WINDOW_RST  = 7'd16;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_UPD
	} state_t;

	// One frame slot; slot position in the chain is its recency rank.
	typedef struct packed {
		logic              valid;
		logic              dirty;
		logic [PAGE_W-1:0] page;
	} entry_t;

	// Outcome of the lookup cycle, consumed by the update cycle.
	typedef struct packed {
		logic                  hit;
		logic                  evict;
		logic                  wb;
		logic                  new_dirty;
		logic                  grow;
		logic [MAX_FRAMES-1:0] pos_oh;
		logic [MAX_FRAMES-1:0] mask;
	} sel_t;

endpackage

FILE: src/cflru_cell.sv
// One frame slot of the recency chain: holds a page, its valid and dirty marks.
// Depends on cflru_pkg.
module cflru_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      shift,
	input  cflru_pkg::entry_t         nb,
	input  logic [cflru_pkg::PAGE_W-1:0] req_page,
	output cflru_pkg::entry_t         ent,
	output logic                      match
);

	logic                         valid_q;
	logic                         dirty_q;
	logic [cflru_pkg::PAGE_W-1:0] page_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			dirty_q <= 1'b0;
		end else if (shift) begin
			valid_q <= nb.valid;
			dirty_q <= nb.dirty;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			page_q <= nb.page;
		end
	end

	assign ent.valid = valid_q;
	assign ent.dirty = dirty_q;
	assign ent.page  = page_q;
	assign match     = valid_q && (page_q == req_page);

endmodule

FILE: src/cflru_sel.sv
// Lookup decision: hit position, insert slot, clean-first victim or LRU fallback victim in the chain.
// Depends on cflru_pkg.
module cflru_sel (
	input  logic [cflru_pkg::MAX_FRAMES-1:0] valid_vec,
	input  logic [cflru_pkg::MAX_FRAMES-1:0] dirty_vec,
	input  logic [cflru_pkg::MAX_FRAMES-1:0] match_vec,
	input  logic [cflru_pkg::CNT_W-1:0]      filled,
	input  logic [cflru_pkg::CFG_W-1:0]      frames_in_use,
	input  logic [cflru_pkg::CFG_W-1:0]      clean_window,
	input  logic                             is_write,
	output cflru_pkg::sel_t                  sel
);

	localparam int N = cflru_pkg::MAX_FRAMES;
	localparam int W = cflru_pkg::CMP_W;

	logic [W-1:0] fil_w;
	logic [W-1:0] fiu_w;
	logic [W-1:0] cw_w;
	logic [W-1:0] limit;
	logic [W-1:0] win;
	logic [W-1:0] lo;
	logic         full;
	logic         hit;
	logic         hit_dirty;
	logic         any_clean;
	logic [N-1:0] cand;
	logic [N-1:0] cand_rev;
	logic [N-1:0] pick_rev;
	logic [N-1:0] pick;
	logic [N-1:0] ins_oh;
	logic [N-1:0] lru_oh;
	logic [N-1:0] pos_oh;

	always_comb begin
		fil_w = W'(filled);
		fiu_w = W'(frames_in_use);
		cw_w  = W'(clean_window);

		if (fiu_w == '0) begin
			limit = W'(1);
		end else if (fiu_w > W'(N)) begin
			limit = W'(N);
		end else begin
			limit = fiu_w;
		end

		win = (cw_w == '0) ? W'(1) : cw_w;
		if (win > limit) begin
			win = limit;
		end
		if (win > fil_w) begin
			win = fil_w;
		end
		lo   = fil_w - win;
		full = !(fil_w < limit);
	end

	always_comb begin
		for (int i = 0; i < N; i++) begin
			cand[i]   = valid_vec[i] && !dirty_vec[i] && (W'(i) >= lo);
			ins_oh[i] = (W'(i) == fil_w);
			lru_oh[i] = (W'(i) == fil_w - W'(1));
		end
		// least recent clean slot = highest set bit of cand
		for (int i = 0; i < N; i++) begin
			cand_rev[i] = cand[N-1-i];
		end
		pick_rev = cand_rev & (~cand_rev + N'(1));
		for (int i = 0; i < N; i++) begin
			pick[i] = pick_rev[N-1-i];
		end
	end

	assign hit       = |match_vec;
	assign hit_dirty = |(match_vec & dirty_vec);
	assign any_clean = |cand;

	always_comb begin
		priority if (hit) begin
			pos_oh = match_vec;
		end else if (!full) begin
			pos_oh = ins_oh;
		end else if (any_clean) begin
			pos_oh = pick;
		end else begin
			pos_oh = lru_oh;
		end
	end

	always_comb begin
		sel.hit       = hit;
		sel.evict     = !hit && full;
		sel.wb        = !hit && full && !any_clean;
		sel.new_dirty = hit ? (hit_dirty || is_write) : is_write;
		sel.grow      = !hit && !full;
		sel.pos_oh    = pos_oh;
		// slots from the head through the chosen slot move one place down the chain
		sel.mask      = pos_oh | (pos_oh - N'(1));
	end

endmodule

FILE: src/clean_first_lru_page_frames_top.sv
// Clean-first LRU page frame tracker: a chain of frame cells ordered by recency.
// Depends on cflru_pkg, cflru_cell and cflru_sel.
//
// Each access has a compare state (match the page against every cell, pick
// the slot) and an update state (shift the chain, update the counters). A new
// access may start in the update state, before the last is through; busy is
// high only in the compare state. The result word shows on the outputs for
// one cycle under done, the cycle after the update, and must be captured then.
// Frame limit and clean window are written through cfg_we/cfg_idx/cfg_data
// by the user only while no access is in flight; the block does not enforce it.
// Limit clamps to 1..64; window clamps to 1..limit, and to the filled count.
module clean_first_lru_page_frames_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [cflru_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [cflru_pkg::CFG_W-1:0]         cfg_data,
	input  logic                                start,
	output logic                                busy,
	input  logic                                is_write,
	input  logic [cflru_pkg::ADDR_W-1:0]        byte_address,
	output logic                                done,
	output logic                                hit,
	output logic                                evicted,
	output logic [cflru_pkg::PAGE_W-1:0]        evicted_page,
	output logic                                write_back,
	output logic [cflru_pkg::TOT_W-1:0]         hit_total,
	output logic [cflru_pkg::TOT_W-1:0]         miss_total,
	output logic [cflru_pkg::TOT_W-1:0]         write_back_total
);

	localparam int N = cflru_pkg::MAX_FRAMES;

	cflru_pkg::state_t state_q;
	cflru_pkg::state_t state_d;

	logic                          accept;
	logic                          upd_en;
	logic [cflru_pkg::CFG_W-1:0]   fiu_q;
	logic [cflru_pkg::CFG_W-1:0]   cw_q;
	logic                          req_wr_q;
	logic [cflru_pkg::PAGE_W-1:0]  req_page_q;
	logic [cflru_pkg::CNT_W-1:0]   filled_q;
	cflru_pkg::sel_t               sel_d;
	cflru_pkg::sel_t               sel_q;

	cflru_pkg::entry_t             ent [N];
	cflru_pkg::entry_t             nb  [N];
	cflru_pkg::entry_t             front;
	logic [N-1:0]                  valid_vec;
	logic [N-1:0]                  dirty_vec;
	logic [N-1:0]                  match_vec;
	logic [cflru_pkg::PAGE_W-1:0]  ev_page;

	logic                          done_q;
	logic                          hit_q;
	logic                          evicted_q;
	logic [cflru_pkg::PAGE_W-1:0]  ev_page_q;
	logic                          wb_q;
	logic [cflru_pkg::TOT_W-1:0]   hit_cnt_q;
	logic [cflru_pkg::TOT_W-1:0]   miss_cnt_q;
	logic [cflru_pkg::TOT_W-1:0]   wb_cnt_q;

	// ---------------- control ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cflru_pkg::S_IDLE: if (start) state_d = cflru_pkg::S_CMP;
			cflru_pkg::S_CMP:  state_d = cflru_pkg::S_UPD;
			cflru_pkg::S_UPD:  state_d = start ? cflru_pkg::S_CMP : cflru_pkg::S_IDLE;
			default:           state_d = cflru_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		busy   = 1'b0;
		upd_en = 1'b0;
		unique case (state_q)
			cflru_pkg::S_IDLE: ;
			cflru_pkg::S_CMP:  busy = 1'b1;
			cflru_pkg::S_UPD:  upd_en = 1'b1;
			default:           busy = 1'b1;
		endcase
	end

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cflru_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------- config ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q <= cflru_pkg::FRAMES_IN_USE_RST;
			cw_q  <= cflru_pkg::CLEAN_WINDOW_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				cflru_pkg::REG_FRAMES_IN_USE: fiu_q <= cfg_data;
				cflru_pkg::REG_CLEAN_WINDOW:  cw_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- request word ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			req_wr_q   <= is_write;
			req_page_q <= byte_address[cflru_pkg::ADDR_W-1:cflru_pkg::PAGE_SHIFT];
		end
	end

	// ---------------- frame chain ----------------
	assign front.valid = 1'b1;
	assign front.dirty = sel_q.new_dirty;
	assign front.page  = req_page_q;

	for (genvar i = 0; i < N; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign nb[i] = front;
		end else begin : g_link
			assign nb[i] = ent[i-1];
		end

		cflru_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (upd_en && sel_q.mask[i]),
			.nb       (nb[i]),
			.req_page (req_page_q),
			.ent      (ent[i]),
			.match    (match_vec[i])
		);

		assign valid_vec[i] = ent[i].valid;
		assign dirty_vec[i] = ent[i].dirty;
	end

	cflru_sel u_sel (
		.valid_vec     (valid_vec),
		.dirty_vec     (dirty_vec),
		.match_vec     (match_vec),
		.filled        (filled_q),
		.frames_in_use (fiu_q),
		.clean_window  (cw_q),
		.is_write      (req_wr_q),
		.sel           (sel_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= '0;
		end else if (state_q == cflru_pkg::S_CMP) begin
			sel_q <= sel_d;
		end
	end

	always_comb begin
		ev_page = '0;
		for (int i = 0; i < N; i++) begin
			ev_page = ev_page | (sel_q.pos_oh[i] ? ent[i].page : '0);
		end
	end

	// ---------------- counters and result word ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q   <= '0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
			wb_cnt_q   <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= upd_en;
			if (upd_en) begin
				if (sel_q.grow) filled_q <= filled_q + cflru_pkg::CNT_W'(1);
				if (sel_q.hit && hit_cnt_q != '1)
					hit_cnt_q <= hit_cnt_q + cflru_pkg::TOT_W'(1);
				if (!sel_q.hit && miss_cnt_q != '1)
					miss_cnt_q <= miss_cnt_q + cflru_pkg::TOT_W'(1);
				if (sel_q.wb && wb_cnt_q != '1)
					wb_cnt_q <= wb_cnt_q + cflru_pkg::TOT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_en) begin
			hit_q     <= sel_q.hit;
			evicted_q <= sel_q.evict;
			ev_page_q <= sel_q.evict ? ev_page : '0;
			wb_q      <= sel_q.wb;
		end
	end

	assign done             = done_q;
	assign hit              = hit_q;
	assign evicted          = evicted_q;
	assign evicted_page     = ev_page_q;
	assign write_back       = wb_q;
	assign hit_total        = hit_cnt_q;
	assign miss_total       = miss_cnt_q;
	assign write_back_total = wb_cnt_q;

	// ---------------- assertions ----------------
	a_filled_bound: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= cflru_pkg::CNT_W'(N))
		else $error("filled count above frame count");

	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec & (valid_vec + N'(1))) == '0)
		&& ($countones(valid_vec) == int'(filled_q)))
		else $error("valid slots not a prefix matching filled count");

	a_pos_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		upd_en |-> $onehot(sel_q.pos_oh))
		else $error("update slot not one-hot");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		upd_en |=> done)
		else $error("result word missing after update");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(hit && evicted) && (!write_back || evicted))
		else $error("inconsistent result flags");

endmodule

FILE: tb/clean_first_lru_page_frames_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for clean_first_lru_page_frames_top: directed and random accesses
// checked against a behavioral frame table. Depends on cflru_pkg and the top level.
module clean_first_lru_page_frames_top_tb;

	localparam int STALL_LIMIT   = 2000;
	localparam int POOL_DEPTH    = 128;
	localparam int OUTCOME_DEPTH = 8;

	typedef struct packed {
		logic                         was_hit;
		logic                         evicted;
		logic [cflru_pkg::PAGE_W-1:0] victim_page;
		logic                         needs_write_back;
		logic [cflru_pkg::TOT_W-1:0]  hits;
		logic [cflru_pkg::TOT_W-1:0]  faults;
		logic [cflru_pkg::TOT_W-1:0]  write_backs;
	} frame_outcome_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [cflru_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [cflru_pkg::CFG_W-1:0]     cfg_data;
	logic                            start;
	logic                            busy;
	logic                            is_write;
	logic [cflru_pkg::ADDR_W-1:0]    byte_address;
	logic                            done;
	logic                            hit;
	logic                            evicted;
	logic [cflru_pkg::PAGE_W-1:0]    evicted_page;
	logic                            write_back;
	logic [cflru_pkg::TOT_W-1:0]     hit_total;
	logic [cflru_pkg::TOT_W-1:0]     miss_total;
	logic [cflru_pkg::TOT_W-1:0]     write_back_total;

	// mirror of the frame table and registers
	logic [cflru_pkg::PAGE_W-1:0] mirror_page [cflru_pkg::MAX_FRAMES];
	bit                           mirror_valid [cflru_pkg::MAX_FRAMES];
	bit                           mirror_dirty [cflru_pkg::MAX_FRAMES];
	int                           mirror_rank [cflru_pkg::MAX_FRAMES];
	int                           filled_count = 0;
	logic [cflru_pkg::TOT_W-1:0]  hits_seen = '0;
	logic [cflru_pkg::TOT_W-1:0]  faults_seen = '0;
	logic [cflru_pkg::TOT_W-1:0]  flushes_seen = '0;
	logic [cflru_pkg::CFG_W-1:0]  frame_limit_reg = cflru_pkg::FRAMES_IN_USE_RST;
	logic [cflru_pkg::CFG_W-1:0]  window_reg = cflru_pkg::CLEAN_WINDOW_RST;

	// expected result words, oldest at due_rd
	frame_outcome_t               outcomes_due [OUTCOME_DEPTH];
	int                           due_wr = 0;
	int                           due_rd = 0;
	logic [cflru_pkg::PAGE_W-1:0] page_pool [POOL_DEPTH];
	int                           idle_pct = 0;
	int                           mismatches = 0;
	int                           stall_cycles = 0;

	clean_first_lru_page_frames_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.is_write(is_write),
		.byte_address(byte_address),
		.done(done),
		.hit(hit),
		.evicted(evicted),
		.evicted_page(evicted_page),
		.write_back(write_back),
		.hit_total(hit_total),
		.miss_total(miss_total),
		.write_back_total(write_back_total)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [cflru_pkg::TOT_W-1:0] sat_inc(
			input logic [cflru_pkg::TOT_W-1:0] v);
		return (v == '1) ? v : v + cflru_pkg::TOT_W'(1);
	endfunction

	function automatic int frame_at_rank(input int r);
		int idx;
		idx = -1;
		for (int i = 0; i < cflru_pkg::MAX_FRAMES; i++)
			if (idx < 0 && mirror_valid[i] && mirror_rank[i] == r)
				idx = i;
		return idx;
	endfunction

	// frames more recent than f slide down one rank, f goes to rank 0
	function automatic void make_most_recent(input int f);
		int r;
		r = mirror_rank[f];
		for (int i = 0; i < cflru_pkg::MAX_FRAMES; i++)
			if (mirror_valid[i] && i != f && mirror_rank[i] < r)
				mirror_rank[i]++;
		mirror_rank[f] = 0;
	endfunction

	function automatic logic [cflru_pkg::PAGE_W-1:0] random_page();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[cflru_pkg::PAGE_W-1:0];
	endfunction

	task automatic track_access(input logic wr, input logic [cflru_pkg::ADDR_W-1:0] addr);
		frame_outcome_t res;
		logic [cflru_pkg::PAGE_W-1:0] pg;
		int limit, win, found, victim, slot, f;
		res = '0;
		pg = addr[cflru_pkg::ADDR_W-1:cflru_pkg::PAGE_SHIFT];
		limit = int'(frame_limit_reg);
		if (limit < 1) limit = 1;
		if (limit > cflru_pkg::MAX_FRAMES) limit = cflru_pkg::MAX_FRAMES;
		found = -1;
		for (int i = 0; i < cflru_pkg::MAX_FRAMES; i++)
			if (found < 0 && mirror_valid[i] && mirror_page[i] == pg)
				found = i;
		if (found >= 0) begin
			res.was_hit = 1'b1;
			hits_seen = sat_inc(hits_seen);
			if (wr)
				mirror_dirty[found] = 1'b1;
			make_most_recent(found);
		end else begin
			faults_seen = sat_inc(faults_seen);
			if (filled_count < limit) begin
				slot = filled_count;
				filled_count++;
				mirror_valid[slot] = 1'b1;
				mirror_rank[slot] = filled_count - 1;
			end else begin
				win = int'(window_reg);
				if (win < 1) win = 1;
				if (win > limit) win = limit;
				if (win > filled_count) win = filled_count;
				// oldest clean frame inside the window wins
				victim = -1;
				for (int k = 0; k < win; k++) begin
					f = frame_at_rank(filled_count - 1 - k);
					if (victim < 0 && f >= 0 && !mirror_dirty[f])
						victim = f;
				end
				if (victim < 0) begin
					victim = frame_at_rank(filled_count - 1);
					if (victim < 0) victim = 0;
					res.needs_write_back = mirror_dirty[victim];
					if (res.needs_write_back)
						flushes_seen = sat_inc(flushes_seen);
				end
				res.evicted = 1'b1;
				res.victim_page = mirror_page[victim];
				slot = victim;
			end
			mirror_page[slot] = pg;
			mirror_dirty[slot] = wr;
			make_most_recent(slot);
		end
		res.hits = hits_seen;
		res.faults = faults_seen;
		res.write_backs = flushes_seen;
		outcomes_due[due_wr % OUTCOME_DEPTH] = res;
		due_wr++;
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_access(input logic wr, input logic [cflru_pkg::ADDR_W-1:0] addr);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		is_write <= wr;
		byte_address <= addr;
		do @(posedge clk); while (busy);
		track_access(wr, addr);
		@(negedge clk);
	endtask

	task automatic settle();
		start <= 1'b0;
		while (due_wr != due_rd)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apply_config(input logic [cflru_pkg::CFG_W-1:0] limit,
			input logic [cflru_pkg::CFG_W-1:0] window);
		cfg_we <= 1'b1;
		cfg_idx <= cflru_pkg::REG_FRAMES_IN_USE;
		cfg_data <= limit;
		@(negedge clk);
		cfg_idx <= cflru_pkg::REG_CLEAN_WINDOW;
		cfg_data <= window;
		@(negedge clk);
		cfg_we <= 1'b0;
		frame_limit_reg = limit;
		window_reg = window;
	endtask

	task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %0h actual %0h", $time, what, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		frame_outcome_t want;
		if (arst_n && done) begin
			if (due_wr == due_rd) begin
				$display("%0t ns: result word with nothing pending", $time);
				mismatches++;
			end else begin
				want = outcomes_due[due_rd % OUTCOME_DEPTH];
				due_rd++;
				check_field("hit", 64'(want.was_hit), 64'(hit));
				check_field("evicted", 64'(want.evicted), 64'(evicted));
				check_field("evicted_page", 64'(want.victim_page), 64'(evicted_page));
				check_field("write_back", 64'(want.needs_write_back), 64'(write_back));
				check_field("hit_total", 64'(want.hits), 64'(hit_total));
				check_field("miss_total", 64'(want.faults), 64'(miss_total));
				check_field("write_back_total", 64'(want.write_backs),
					64'(write_back_total));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic test_address_extremes();
		send_access(1'b0, 64'h0);
		send_access(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
		send_access(1'b0, 64'h0000_0000_0000_0FFF);
		send_access(1'b1, 64'h0000_0000_0000_1000);
		send_access(1'b0, 64'hFFFF_FFFF_FFFF_F000);
		send_access(1'b1, 64'h8000_0000_0000_0000);
		send_access(1'b0, 64'h5555_5555_5555_5555);
		send_access(1'b1, 64'hAAAA_AAAA_AAAA_AAAA);
		send_access(1'b1, 64'h0000_0000_0000_0123);
		send_access(1'b0, 64'h0000_0000_0000_1FFF);
	endtask

	// limit below the filled count: every miss evicts, clean first then dirty
	task automatic test_lowered_limit();
		settle();
		apply_config(7'd2, 7'd1);
		send_access(1'b0, 64'h0000_0000_0002_0000);
		send_access(1'b1, 64'h0000_0000_0000_3000);
		settle();
		apply_config(7'd2, 7'd64);
		send_access(1'b0, 64'h0000_0000_0000_4000);
		send_access(1'b0, 64'h0000_0000_0002_0ABC);
		send_access(1'b1, 64'h0000_0000_0000_9000);
	endtask

	task automatic test_clamped_registers();
		settle();
		apply_config(7'd0, 7'd0);
		send_access(1'b1, 64'h0000_0000_0000_5000);
		send_access(1'b0, 64'h0000_0000_0000_5FFF);
		send_access(1'b0, 64'h0000_0000_0000_6000);
		settle();
		apply_config(7'd127, 7'd127);
		send_access(1'b1, 64'h0000_0000_0000_7000);
		send_access(1'b0, 64'h0000_0000_0000_7ABC);
	endtask

	// pages mostly come from a pool a bit larger than the frame limit so that
	// hits, clean evictions and write-backs all happen; one in ten is noise
	task automatic run_traffic(input logic [cflru_pkg::CFG_W-1:0] limit,
			input logic [cflru_pkg::CFG_W-1:0] window, input int idle, input int words);
		int lim, span, base, write_pct;
		logic [31:0] rnd;
		logic [cflru_pkg::PAGE_W-1:0] pg;
		logic [cflru_pkg::PAGE_SHIFT-1:0] offs;
		settle();
		apply_config(limit, window);
		idle_pct = idle;
		lim = int'(limit);
		if (lim < 1) lim = 1;
		if (lim > cflru_pkg::MAX_FRAMES) lim = cflru_pkg::MAX_FRAMES;
		span = lim + $urandom_range(1, lim + 2);
		if (span > POOL_DEPTH) span = POOL_DEPTH;
		base = $urandom_range(POOL_DEPTH - 1);
		write_pct = $urandom_range(10, 90);
		repeat (16) page_pool[$urandom_range(POOL_DEPTH - 1)] = random_page();
		repeat (words) begin
			if ($urandom_range(9) == 0)
				pg = random_page();
			else
				pg = page_pool[(base + $urandom_range(span - 1)) % POOL_DEPTH];
			rnd = $urandom;
			offs = rnd[cflru_pkg::PAGE_SHIFT-1:0];
			send_access($urandom_range(99) < write_pct, {pg, offs});
		end
		idle_pct = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		start = 1'b0;
		is_write = 1'b0;
		byte_address = '0;
		for (int i = 0; i < POOL_DEPTH; i++)
			page_pool[i] = random_page();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_address_extremes();
		test_lowered_limit();
		test_clamped_registers();

		run_traffic(7'd1, 7'd1, 0, 160);
		run_traffic(7'd2, 7'd2, 61, 160);
		run_traffic(7'd4, 7'd1, 0, 160);
		run_traffic(7'd8, 7'd3, 19, 160);
		run_traffic(7'd13, 7'd64, 0, 160);
		run_traffic(7'd21, 7'd5, 61, 160);
		run_traffic(7'd32, 7'd16, 0, 160);
		run_traffic(7'd48, 7'd0, 19, 160);
		run_traffic(7'd64, 7'd64, 0, 160);
		run_traffic(7'd127, 7'd127, 61, 160);
		run_traffic(7'd64, 7'd1, 0, 160);
		run_traffic(7'($urandom_range(127)), 7'($urandom_range(127)), 19, 160);

		settle();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
